>>> sv/gcfc_pkg.sv
// gcfc_pkg: shared types and constants of the green chromaticity field classifier
// register indexes, reset values and the pipeline stage payload type
// no dependencies
`default_nettype none

package gcfc_pkg;

  localparam int BYTE_W    = 8;
  localparam int SUM_W     = 10;  // b + g + r, up to 765
  localparam int NUM_W     = 17;  // 510*g + sum, up to 130815
  localparam int DEN_W     = 11;  // 2*sum, up to 1530
  localparam int TRIAL_W   = 19;  // den shifted by up to seven places
  localparam int QUO_W     = 8;
  localparam int DIV_STAGES = 4;
  localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GREEN_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_LOW        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_HIGH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_U_LOW           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_U_HIGH          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V_LOW           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_V_HIGH          = 3'd6;

  localparam logic [BYTE_W-1:0] BOUND_LOW_RESET  = 8'd0;
  localparam logic [BYTE_W-1:0] BOUND_HIGH_RESET = 8'd255;
  localparam logic [BYTE_W-1:0] THRESHOLD_RESET  = 8'd0;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             zero;
    logic             in_range;
  } stage_t;

endpackage

`default_nettype wire

>>> sv/green_chromaticity_field_classifier_unit.sv
// green_chromaticity_field_classifier_unit: per-pixel field mask from green share and yuv bounds
// top level; uses gcfc_pkg for types and register indexes
//
// usage
//   input channel in_valid/in_ready carries one pixel per transaction: blue, green, red,
//   luma, chroma_u, chroma_v. output channel out_valid/out_ready returns green_ratio,
//   round(255*g/(b+g+r)) with ties up and 0 for a black pixel, and field_pixel.
//   the seven bound registers are written through cfg_wr_en/cfg_index/cfg_data; indexes
//   above six are ignored. the user must write them only while the block is idle (unenforced).
// pipeline and throughput
//   a pixel passes through six register stages: one preparation stage, four restoring
//   divider stages of two quotient bits each, one output register.
//   one pixel per cycle sustained while out_ready is high; the divider pipeline sets the latency.
// reset
//   rst empties every stage and loads the register reset values.
// stalls
//   each stage holds while the one after it is full and stalled; empty stages keep
//   filling, so up to six pixels are taken while out_ready is low.
`default_nettype none

module green_chromaticity_field_classifier_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   blue,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   green,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   red,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   luma,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   chroma_u,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   chroma_v,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [gcfc_pkg::BYTE_W-1:0]        green_ratio,
  output logic                               field_pixel,
  input  wire logic                          cfg_wr_en,
  input  wire logic [gcfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gcfc_pkg::BYTE_W-1:0]   cfg_data
);

  import gcfc_pkg::*;

  logic [BYTE_W-1:0] green_threshold;
  logic [BYTE_W-1:0] luma_low;
  logic [BYTE_W-1:0] luma_high;
  logic [BYTE_W-1:0] u_low;
  logic [BYTE_W-1:0] u_high;
  logic [BYTE_W-1:0] v_low;
  logic [BYTE_W-1:0] v_high;

  logic   vld [0:DIV_STAGES];
  logic   rdy [0:DIV_STAGES+1];
  stage_t st  [0:DIV_STAGES];
  stage_t st_next [0:DIV_STAGES];

  logic [SUM_W-1:0] sum;
  logic [BYTE_W-1:0] ratio_next;
  logic field_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      green_threshold <= THRESHOLD_RESET;
      luma_low        <= BOUND_LOW_RESET;
      luma_high       <= BOUND_HIGH_RESET;
      u_low           <= BOUND_LOW_RESET;
      u_high          <= BOUND_HIGH_RESET;
      v_low           <= BOUND_LOW_RESET;
      v_high          <= BOUND_HIGH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GREEN_THRESHOLD: green_threshold <= cfg_data;
        REG_LUMA_LOW:        luma_low        <= cfg_data;
        REG_LUMA_HIGH:       luma_high       <= cfg_data;
        REG_U_LOW:           u_low           <= cfg_data;
        REG_U_HIGH:          u_high          <= cfg_data;
        REG_V_LOW:           v_low           <= cfg_data;
        REG_V_HIGH:          v_high          <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-stage ready, bubbles collapse
  always_comb begin
    rdy[DIV_STAGES+1] = !out_valid || out_ready;
    for (int i = DIV_STAGES; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    logic [TRIAL_W-1:0] trial;
    int k;
    // preparation: numerator 510*g + sum, denominator 2*sum, yuv window
    sum = SUM_W'(blue) + SUM_W'(green) + SUM_W'(red);
    st_next[0].rem = (NUM_W'(green) << 9) - (NUM_W'(green) << 1) + NUM_W'(sum);
    st_next[0].den = {sum, 1'b0};
    st_next[0].quo = '0;
    st_next[0].zero = (sum == '0);
    st_next[0].in_range = (luma >= luma_low) && (luma <= luma_high)
                       && (chroma_u >= u_low) && (chroma_u <= u_high)
                       && (chroma_v >= v_low) && (chroma_v <= v_high);
    // restoring divider, two quotient bits per stage, msb first
    for (int j = 1; j <= DIV_STAGES; j++) begin
      st_next[j] = st[j-1];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        k = QUO_W - 1 - BITS_PER_STAGE * (j - 1) - b;
        trial = TRIAL_W'(st_next[j].den) << k;
        if (TRIAL_W'(st_next[j].rem) >= trial) begin
          st_next[j].rem = st_next[j].rem - NUM_W'(trial);
          st_next[j].quo[3'(k)] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ratio_next = st[DIV_STAGES].zero ? '0 : st[DIV_STAGES].quo;
    field_next = (ratio_next > green_threshold) && st[DIV_STAGES].in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
        vld[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i <= DIV_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (rdy[DIV_STAGES+1]) begin
        out_valid <= vld[DIV_STAGES];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= DIV_STAGES; i++) begin
      if (rdy[i]) begin
        st[i] <= st_next[i];
      end
    end
    if (rdy[DIV_STAGES+1]) begin
      green_ratio <= ratio_next;
      field_pixel <= field_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/gcfc_checker.sv
// gcfc_checker: port-level checks on the green chromaticity field classifier
// bound to green_chromaticity_field_classifier_unit; uses gcfc_pkg for widths
`default_nettype none

module gcfc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [gcfc_pkg::BYTE_W-1:0] green_ratio,
  input wire logic                        field_pixel
);

  import gcfc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(green_ratio) && $stable(field_pixel))
    else $error("output transaction changed while stalled");

  // field needs a ratio above some threshold, so never zero
  a_field_ratio: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_pixel |-> green_ratio != '0)
    else $error("field pixel with zero green ratio");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // an idle output side never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind green_chromaticity_field_classifier_unit gcfc_checker u_gcfc_checker (.*);

`default_nettype wire

>>> test/tb_green_chromaticity_field_classifier_unit.sv
// tb_green_chromaticity_field_classifier_unit: self-checking bench for the green share field classifier
// directed pixel table then randomised pixels over several bound settings, random idling on both sides
// depends on gcfc_pkg and green_chromaticity_field_classifier_unit
`timescale 1ns / 1ps

module tb_green_chromaticity_field_classifier_unit;
  import gcfc_pkg::*;

  localparam int unsigned FULL_SCALE = 255;
  localparam int REG_COUNT = 7;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int NUM_FIXED = 7;
  localparam int NUM_RANDOM = 3;
  localparam int NUM_DIRECTED = 19;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
  } pixel_t;

  typedef struct packed {
    logic [7:0] green_ratio;
    logic       field_pixel;
  } verdict_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] luma_low;
    logic [7:0] luma_high;
    logic [7:0] u_low;
    logic [7:0] u_high;
    logic [7:0] v_low;
    logic [7:0] v_high;
  } bounds_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       typed;
    logic [7:0] want_ratio;
    logic       want_field;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] blue = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] red = 8'd0;
  logic [7:0] luma = 8'd0;
  logic [7:0] chroma_u = 8'd0;
  logic [7:0] chroma_v = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] green_ratio;
  logic field_pixel;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'd0;

  logic drv_typed = 1'b0;
  verdict_t drv_want = '0;

  logic [7:0] cfg_copy [REG_COUNT];
  verdict_t pending_verdicts [$];
  int mismatch_count = 0;
  int src_calm = 0;
  bounds_t active_bounds;

  localparam bounds_t RESET_BOUNDS = '{THRESHOLD_RESET, BOUND_LOW_RESET, BOUND_HIGH_RESET,
                                       BOUND_LOW_RESET, BOUND_HIGH_RESET,
                                       BOUND_LOW_RESET, BOUND_HIGH_RESET};

  // thresholds and yuv windows, extremes and inverted windows among them
  bounds_t fixed_settings [NUM_FIXED] = '{
    '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255},
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd50, 8'd200, 8'd100, 8'd0, 8'd255, 8'd0, 8'd255},
    '{8'd100, 8'd40, 8'd220, 8'd0, 8'd120, 8'd0, 8'd130},
    '{8'd128, 8'd0, 8'd255, 8'd90, 8'd60, 8'd0, 8'd255},
    '{8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd200, 8'd100}
  };

  // run under reset bounds: threshold 0, full windows
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0},
    '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 1'b1},
    '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0},
    '{8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 1'b1, 8'd85, 1'b1},
    '{8'd0, 8'd1, 8'd0, 8'd0, 8'd255, 8'd0, 1'b1, 8'd255, 1'b1},
    '{8'd0, 8'd1, 8'd1, 8'd255, 8'd0, 8'd255, 1'b1, 8'd128, 1'b1},
    '{8'd1, 8'd1, 8'd0, 8'd16, 8'd128, 8'd240, 1'b1, 8'd128, 1'b1},
    '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0},
    '{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0, 1'b0},
    '{8'd255, 8'd254, 8'd255, 8'd1, 8'd254, 8'd127, 1'b0, 8'd0, 1'b0},
    '{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0, 8'd0, 1'b0},
    '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0, 8'd0, 1'b0},
    '{8'd2, 8'd1, 8'd0, 8'd128, 8'd127, 8'd128, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd127, 1'b0, 8'd0, 1'b0},
    '{8'd1, 8'd3, 8'd0, 8'd200, 8'd100, 8'd50, 1'b0, 8'd0, 1'b0},
    '{8'd0, 8'd128, 8'd127, 8'd0, 8'd255, 8'd255, 1'b0, 8'd0, 1'b0},
    '{8'd1, 8'd2, 8'd1, 8'd255, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0},
    '{8'd9, 8'd2, 8'd9, 8'd3, 8'd200, 8'd17, 1'b0, 8'd0, 1'b0},
    '{8'd1, 8'd254, 8'd0, 8'd128, 8'd128, 8'd128, 1'b0, 8'd0, 1'b0}
  };

  green_chromaticity_field_classifier_unit dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic in_window(input logic [7:0] x, lo, hi);
    return x >= lo && x <= hi;
  endfunction

  function automatic verdict_t classify_pixel(input pixel_t p);
    int unsigned colour_sum;
    verdict_t v;
    colour_sum = p.blue + p.green + p.red;
    if (colour_sum == 0) begin
      v.green_ratio = 8'd0;
    end else begin
      // ties round up
      v.green_ratio = 8'((2 * FULL_SCALE * p.green + colour_sum) / (2 * colour_sum));
    end
    v.field_pixel = v.green_ratio > cfg_copy[REG_GREEN_THRESHOLD]
                    && in_window(p.luma, cfg_copy[REG_LUMA_LOW], cfg_copy[REG_LUMA_HIGH])
                    && in_window(p.chroma_u, cfg_copy[REG_U_LOW], cfg_copy[REG_U_HIGH])
                    && in_window(p.chroma_v, cfg_copy[REG_V_LOW], cfg_copy[REG_V_HIGH]);
    return v;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = int'($urandom_range(20, 60));
      return 0;
    end
    return int'($urandom_range(0, 10));
  endfunction

  function automatic logic [7:0] near_bound(input logic [7:0] lo, hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return lo - 8'd1;
      3: return hi + 8'd1;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic void order_pair(inout logic [7:0] lo, hi);
    logic [7:0] t;
    if (lo > hi && $urandom_range(0, 3) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
  endfunction

  function automatic bounds_t random_bounds();
    bounds_t b;
    b = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom), 8'($urandom)};
    order_pair(b.luma_low, b.luma_high);
    order_pair(b.u_low, b.u_high);
    order_pair(b.v_low, b.v_high);
    return b;
  endfunction

  function automatic pixel_t random_pixel(input bounds_t b);
    pixel_t p;
    int unsigned mode;
    p = '{8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom), 8'($urandom)};
    mode = $urandom_range(0, 3);
    if (mode == 2) begin
      // green dominant
      p.green = 8'($urandom_range(64, 255));
      p.blue = 8'($urandom_range(0, 60));
      p.red = 8'($urandom_range(0, 60));
    end else if (mode == 3) begin
      // dim pixels: black, ties and small sums
      p.blue = 8'($urandom_range(0, 3));
      p.green = 8'($urandom_range(0, 3));
      p.red = 8'($urandom_range(0, 3));
    end
    if (mode != 0) begin
      p.luma = near_bound(b.luma_low, b.luma_high);
      p.chroma_u = near_bound(b.u_low, b.u_high);
      p.chroma_v = near_bound(b.v_low, b.v_high);
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_t px, input logic typed, input verdict_t want);
    int gap;
    gap = draw_wait(src_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    blue <= px.blue;
    green <= px.green;
    red <= px.red;
    luma <= px.luma;
    chroma_u <= px.chroma_u;
    chroma_v <= px.chroma_v;
    drv_typed <= typed;
    drv_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_pixels();
    repeat (ITEMS_PER_PHASE) send_pixel(random_pixel(active_bounds), 1'b0, verdict_t'('0));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_bounds(input bounds_t b);
    write_reg(REG_GREEN_THRESHOLD, b.threshold);
    write_reg(REG_LUMA_LOW, b.luma_low);
    write_reg(REG_LUMA_HIGH, b.luma_high);
    write_reg(REG_U_LOW, b.u_low);
    write_reg(REG_U_HIGH, b.u_high);
    write_reg(REG_V_LOW, b.v_low);
    write_reg(REG_V_HIGH, b.v_high);
    // unmapped index, must leave every register alone
    write_reg(REG_UNMAPPED, 8'($urandom));
    cfg_wr_en <= 1'b0;
    active_bounds = b;
  endtask

  // register copy, expected verdicts and comparison
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    verdict_t fresh;
    if (rst) begin
      cfg_copy[REG_GREEN_THRESHOLD] = THRESHOLD_RESET;
      cfg_copy[REG_LUMA_LOW] = BOUND_LOW_RESET;
      cfg_copy[REG_LUMA_HIGH] = BOUND_HIGH_RESET;
      cfg_copy[REG_U_LOW] = BOUND_LOW_RESET;
      cfg_copy[REG_U_HIGH] = BOUND_HIGH_RESET;
      cfg_copy[REG_V_LOW] = BOUND_LOW_RESET;
      cfg_copy[REG_V_HIGH] = BOUND_HIGH_RESET;
    end else begin
      if (in_valid && in_ready) begin
        if (drv_typed) begin
          fresh = drv_want;
        end else begin
          fresh = classify_pixel('{blue, green, red, luma, chroma_u, chroma_v});
        end
        pending_verdicts = {pending_verdicts, fresh};
      end
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected transaction, green_ratio %0d field_pixel %0d",
                   $time, green_ratio, field_pixel);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (green_ratio !== want.green_ratio) begin
            $display("%0t: green_ratio expected %0d, actual %0d",
                     $time, want.green_ratio, green_ratio);
            mismatch_count++;
          end
          if (field_pixel !== want.field_pixel) begin
            $display("%0t: field_pixel expected %0d, actual %0d",
                     $time, want.field_pixel, field_pixel);
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en && cfg_index < REG_COUNT) begin
        cfg_copy[cfg_index] = cfg_data;
      end
    end
  end

  initial begin : output_sink
    int stall;
    int calm;
    calm = 0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : pixel_source
    directed_row_t row;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    active_bounds = RESET_BOUNDS;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_pixel('{row.blue, row.green, row.red, row.luma, row.chroma_u, row.chroma_v},
                 row.typed, '{row.want_ratio, row.want_field});
    end
    send_random_pixels();
    for (int k = 0; k < NUM_FIXED + NUM_RANDOM; k++) begin
      wait_idle();
      apply_bounds(k < NUM_FIXED ? fixed_settings[k] : random_bounds());
      send_random_pixels();
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
